FILE: design/sha1bsh_pkg.sv
// ----------------------------------------------------------------------------
// sha1bsh_pkg
// Shared types, constants and round functions of the SHA-1 byte stream hasher.
// ----------------------------------------------------------------------------
package sha1bsh_pkg;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_FINAL,
      ST_EMIT
   } state_type;

   localparam int unsigned NUM_CHAIN  = 5;
   localparam int unsigned NUM_ROUNDS = 80;
   localparam int unsigned BLOCK_BITS = 512;

   typedef logic [31:0] word_type;

   // Initial chaining value.
   localparam word_type IV_WORDS [NUM_CHAIN] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   // Round constants, one per group of twenty rounds.
   localparam word_type K_00_19 = 32'h5A827999;
   localparam word_type K_20_39 = 32'h6ED9EBA1;
   localparam word_type K_40_59 = 32'h8F1BBCDC;
   localparam word_type K_60_79 = 32'hCA62C1D6;

   // Padding marker byte and the block position where the length field starts.
   localparam logic [7:0] PAD_MARKER  = 8'h80;
   localparam logic [5:0] LEN_POS     = 6'd56;
   localparam logic [5:0] LAST_POS    = 6'd63;
   localparam logic [2:0] LAST_WORD   = 3'd4;
   localparam logic [2:0] LAST_LENIDX = 3'd7;
   localparam logic [6:0] LAST_ROUND  = 7'(NUM_ROUNDS - 1);

   // Boolean function of the round.
   function automatic word_type sha1_f(input logic [6:0] rnd, input word_type b,
                                       input word_type c, input word_type d);
      word_type r;
      if (rnd < 7'd20) begin
         r = (b & c) | (~b & d);
      end else if (rnd < 7'd40) begin
         r = b ^ c ^ d;
      end else if (rnd < 7'd60) begin
         r = (b & c) | (b & d) | (c & d);
      end else begin
         r = b ^ c ^ d;
      end
      return r;
   endfunction

   // Additive constant of the round.
   function automatic word_type sha1_k(input logic [6:0] rnd);
      word_type r;
      if (rnd < 7'd20) begin
         r = K_00_19;
      end else if (rnd < 7'd40) begin
         r = K_20_39;
      end else if (rnd < 7'd60) begin
         r = K_40_59;
      end else begin
         r = K_60_79;
      end
      return r;
   endfunction

endpackage

FILE: design/sha1_byte_stream_hasher_unit.sv
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher_unit
// SHA-1 over a byte stream: collects bytes, compresses each 64-byte block
// with one shared round unit, pads on finish and streams out the digest.
// ----------------------------------------------------------------------------
//  Channel | Direction | Word                          | Sideband
//  req_    | in        | tdata[7:0] data_byte          | tuser = kind
//  rsp_    | out       | tdata[31:0] digest_word,      | tlast = last_word
//          |           | tdata[34:32] word_index       |
//
// An appended byte is shifted into the block window; the byte that fills a block
// starts 80 rounds through the single round adder, then a fold into the
// chaining words. A finish word feeds 9 to 72 padding bytes at one per cycle,
// with one or two compressions, then loads five digest words into the output
// register. req_tready is low whenever the sequencer is busy. Reset is
// synchronous and restores the initial vector and a zero bit count. A stalled
// rsp_ side holds the output register, the digest sequencing and, in ST_EMIT, req_tready.
module sha1_byte_stream_hasher_unit
   import sha1bsh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] digest_word, [34:32] word_index
   output logic        rsp_tlast
);

   state_type state_ff, state_in;

   word_type chain_ff [NUM_CHAIN];
   word_type chain_in [NUM_CHAIN];
   word_type a_ff, b_ff, c_ff, d_ff, e_ff;
   word_type a_in, b_in, c_in, d_in, e_in;
   logic [6:0] round_ff, round_in;
   logic [BLOCK_BITS-1:0] win_ff, win_in;
   logic [63:0] bit_count_ff, bit_count_in;
   logic [63:0] len_ff, len_in;
   logic marker_ff, marker_in;
   logic len_phase_ff, len_phase_in;
   logic [2:0] len_idx_ff, len_idx_in;
   logic len_done_ff, len_done_in;
   logic pad_active_ff, pad_active_in;
   logic [2:0] emit_idx_ff, emit_idx_in;
   logic rsp_valid_ff, rsp_valid_in;
   word_type rsp_word_ff, rsp_word_in;
   logic [2:0] rsp_index_ff, rsp_index_in;
   logic rsp_last_ff, rsp_last_in;

   logic accept;
   logic finish;
   logic byte_push;
   logic [7:0] byte_val;
   logic [5:0] pos;
   logic block_full;
   logic pad_len_sel;
   logic load_out;
   word_type sched;
   word_type w0;
   word_type t_sum;

   assign pos = bit_count_ff[8:3];
   assign w0  = win_ff[511:480];

   // Control decode for the current state.
   always_comb begin
      req_tready  = (state_ff == ST_IDLE);
      accept      = req_tvalid && (state_ff == ST_IDLE);
      finish      = accept && req_tuser;
      pad_len_sel = !marker_ff && (len_phase_ff || (pos == LEN_POS));
      byte_push   = 1'b0;
      byte_val    = req_tdata;
      case (state_ff)
         ST_IDLE: begin
            byte_push = accept && !req_tuser;
         end
         ST_PAD: begin
            byte_push = 1'b1;
            if (marker_ff) begin
               byte_val = PAD_MARKER;
            end else if (pad_len_sel) begin
               byte_val = 8'(len_ff >> {~len_idx_ff, 3'b000});
            end else begin
               byte_val = 8'h00;
            end
         end
         default: begin
            byte_push = 1'b0;
         end
      endcase
      block_full = byte_push && (pos == LAST_POS);
      load_out   = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (finish) begin
               state_in = ST_PAD;
            end else if (block_full) begin
               state_in = ST_ROUND;
            end
         end
         ST_PAD: begin
            if (block_full) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (round_ff == LAST_ROUND) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            if (!pad_active_ff) begin
               state_in = ST_IDLE;
            end else if (len_done_ff) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_PAD;
            end
         end
         ST_EMIT: begin
            if (load_out && (emit_idx_ff == LAST_WORD)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Message schedule word and the round sum.
   always_comb begin
      word_type x;
      x      = win_ff[95:64] ^ win_ff[255:224] ^ win_ff[447:416] ^ w0;
      sched  = {x[30:0], x[31]};
      t_sum  = {a_ff[26:0], a_ff[31:27]} + sha1_f(round_ff, b_ff, c_ff, d_ff)
               + e_ff + sha1_k(round_ff) + w0;
   end

   // Block window, working variables and chaining words.
   always_comb begin
      win_in       = win_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      d_in         = d_ff;
      e_in         = e_ff;
      round_in     = round_ff;
      chain_in     = chain_ff;
      bit_count_in = bit_count_ff;
      if (byte_push) begin
         win_in       = {win_ff[BLOCK_BITS-9:0], byte_val};
         bit_count_in = bit_count_ff + 64'd8;
      end else if (state_ff == ST_ROUND) begin
         win_in = {win_ff[BLOCK_BITS-33:0], sched};
      end
      if (block_full) begin
         a_in     = chain_ff[0];
         b_in     = chain_ff[1];
         c_in     = chain_ff[2];
         d_in     = chain_ff[3];
         e_in     = chain_ff[4];
         round_in = 7'd0;
      end else if (state_ff == ST_ROUND) begin
         a_in     = t_sum;
         b_in     = a_ff;
         c_in     = {b_ff[1:0], b_ff[31:2]};
         d_in     = c_ff;
         e_in     = d_ff;
         round_in = round_ff + 7'd1;
      end
      if (state_ff == ST_FINAL) begin
         chain_in[0] = chain_ff[0] + a_ff;
         chain_in[1] = chain_ff[1] + b_ff;
         chain_in[2] = chain_ff[2] + c_ff;
         chain_in[3] = chain_ff[3] + d_ff;
         chain_in[4] = chain_ff[4] + e_ff;
      end
      // The last digest word leaves: start a new message.
      if (load_out && (emit_idx_ff == LAST_WORD)) begin
         chain_in     = IV_WORDS;
         bit_count_in = 64'd0;
      end
   end

   // Padding sequencer.
   always_comb begin
      len_in        = len_ff;
      marker_in     = marker_ff;
      len_phase_in  = len_phase_ff;
      len_idx_in    = len_idx_ff;
      len_done_in   = len_done_ff;
      pad_active_in = pad_active_ff;
      if (finish) begin
         len_in        = bit_count_ff;
         marker_in     = 1'b1;
         len_phase_in  = 1'b0;
         len_idx_in    = 3'd0;
         len_done_in   = 1'b0;
         pad_active_in = 1'b1;
      end else if (state_ff == ST_PAD) begin
         if (marker_ff) begin
            marker_in = 1'b0;
         end else if (pad_len_sel) begin
            len_phase_in = 1'b1;
            len_idx_in   = len_idx_ff + 3'd1;
            if (len_idx_ff == LAST_LENIDX) begin
               len_done_in = 1'b1;
            end
         end
      end
      if (load_out && (emit_idx_ff == LAST_WORD)) begin
         pad_active_in = 1'b0;
      end
   end

   // Output register for the digest words.
   always_comb begin
      emit_idx_in  = emit_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;
      if (finish) begin
         emit_idx_in = 3'd0;
      end
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = chain_ff[emit_idx_ff];
         rsp_index_in = emit_idx_ff;
         rsp_last_in  = (emit_idx_ff == LAST_WORD);
         emit_idx_in  = (emit_idx_ff == LAST_WORD) ? 3'd0 : emit_idx_ff + 3'd1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_index_ff, rsp_word_ff};
   assign rsp_tlast  = rsp_last_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         chain_ff      <= IV_WORDS;
         bit_count_ff  <= 64'd0;
         marker_ff     <= 1'b0;
         len_phase_ff  <= 1'b0;
         len_idx_ff    <= 3'd0;
         len_done_ff   <= 1'b0;
         pad_active_ff <= 1'b0;
         emit_idx_ff   <= 3'd0;
         rsp_valid_ff  <= 1'b0;
         round_ff      <= 7'd0;
      end else begin
         state_ff      <= state_in;
         chain_ff      <= chain_in;
         bit_count_ff  <= bit_count_in;
         marker_ff     <= marker_in;
         len_phase_ff  <= len_phase_in;
         len_idx_ff    <= len_idx_in;
         len_done_ff   <= len_done_in;
         pad_active_ff <= pad_active_in;
         emit_idx_ff   <= emit_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
         round_ff      <= round_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      win_ff       <= win_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      c_ff         <= c_in;
      d_ff         <= d_in;
      e_ff         <= e_in;
      len_ff       <= len_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
   end

`ifndef SYNTH
   // The round counter never runs past the last round.
   a_round_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> (round_ff <= LAST_ROUND))
      else $error("round counter out of range");

   // A finish word starts padding with the marker byte.
   a_finish_pad: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser) |=> ((state_ff == ST_PAD) && marker_ff))
      else $error("finish did not start padding");

   // The length field always ends exactly on a block boundary.
   a_len_end: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_PAD) && pad_len_sel && (len_idx_ff == LAST_LENIDX))
      |-> (pos == LAST_POS))
      else $error("length field misaligned");

   // The digest is only emitted once all padding has been compressed.
   a_emit_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (len_done_ff && pad_active_ff))
      else $error("digest emitted before padding finished");

   // The last flag marks the fifth word only.
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_last_ff == (rsp_index_ff == LAST_WORD)))
      else $error("last flag and word index disagree");
`endif

endmodule

FILE: tb/sha1_byte_stream_hasher_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher_unit_test
// Self-checking test of the SHA-1 byte stream hasher. Message bytes and
// finish words go in on the req_ channel. A local SHA-1 model hashes every
// accepted word and queues the five digest words that each finish produces.
// The rsp_ channel is checked word by word against that queue. Directed
// messages come first, then random messages under several idle and stall
// patterns, and last a long output stall that backs up the input.
// ----------------------------------------------------------------------------
module sha1_byte_stream_hasher_unit_test;

   // Word kinds on req_tuser.
   localparam logic KIND_APPEND = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

   localparam int unsigned DIGEST_WORDS = 5;
   localparam int unsigned HOLD_CYCLES  = 600;
   localparam int unsigned DRAIN_LIMIT  = 20000;
   localparam int unsigned TAIL_CYCLES  = 200;

   localparam logic [31:0] START_CHAIN [DIGEST_WORDS] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] data_byte
   logic        req_tuser;   // [0] kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;   // [31:0] digest_word, [34:32] word_index
   logic        rsp_tlast;

   // Local hash state, advanced on every accepted word.
   logic [31:0]     hash_chain [DIGEST_WORDS];
   logic [7:0]      hash_block [64];
   logic [63:0]     hash_bit_count;
   digest_word_type digest_q[$];
   digest_word_type want_word;

   int unsigned error_count = 0;
   int unsigned tx_idle_pct = 0;
   int unsigned rx_stall_pct = 0;
   int unsigned stall_count = 0;
   logic        hold_trigger = 1'b0;

   sha1_byte_stream_hasher_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard limit on the run time.
   initial begin
      #10ms;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic logic [31:0] rotl32(input logic [31:0] v, input int s);
      return (v << s) | (v >> (32 - s));
   endfunction

   // One 80-round compression of the collected block into the chain.
   function automatic void compress_hash_block();
      logic [31:0] w [80];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int i = 0; i < 16; i++) begin
         w[i] = {hash_block[4*i], hash_block[4*i+1], hash_block[4*i+2], hash_block[4*i+3]};
      end
      for (int i = 16; i < 80; i++) begin
         w[i] = rotl32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
      end
      a = hash_chain[0];
      b = hash_chain[1];
      c = hash_chain[2];
      d = hash_chain[3];
      e = hash_chain[4];
      for (int i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = (b & c) | (~b & d);
            k = 32'h5A827999;
         end else if (i < 40) begin
            f = b ^ c ^ d;
            k = 32'h6ED9EBA1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = 32'h8F1BBCDC;
         end else begin
            f = b ^ c ^ d;
            k = 32'hCA62C1D6;
         end
         t = rotl32(a, 5) + f + e + k + w[i];
         e = d;
         d = c;
         c = rotl32(b, 30);
         b = a;
         a = t;
      end
      hash_chain[0] += a;
      hash_chain[1] += b;
      hash_chain[2] += c;
      hash_chain[3] += d;
      hash_chain[4] += e;
   endfunction

   function automatic void absorb_byte(input logic [7:0] value);
      logic [5:0] pos;
      pos = hash_bit_count[8:3];
      hash_block[pos] = value;
      hash_bit_count += 64'd8;
      if (pos == 6'd63) begin
         compress_hash_block();
      end
   endfunction

   function automatic void start_new_message();
      for (int i = 0; i < DIGEST_WORDS; i++) begin
         hash_chain[i] = START_CHAIN[i];
      end
      hash_bit_count = '0;
   endfunction

   // Advance the local hash by one accepted word; a finish queues the digest.
   function automatic void hash_accepted_word(input logic kind, input logic [7:0] data);
      logic [63:0]     msg_bits;
      digest_word_type dw;
      if (kind == KIND_APPEND) begin
         absorb_byte(data);
      end else begin
         msg_bits = hash_bit_count;
         absorb_byte(8'h80);
         while (hash_bit_count[8:3] != 6'd56) begin
            absorb_byte(8'h00);
         end
         for (int i = 0; i < 8; i++) begin
            absorb_byte(msg_bits[63 - 8*i -: 8]);
         end
         for (int i = 0; i < DIGEST_WORDS; i++) begin
            dw.word  = hash_chain[i];
            dw.index = 3'(i);
            dw.last  = (i == DIGEST_WORDS - 1);
            digest_q.push_back(dw);
         end
         start_new_message();
      end
   endfunction

   // Receiver: random stalls, or a long hold-off when one is requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready  <= 1'b0;
         stall_count <= 0;
      end else if (stall_count != 0) begin
         rsp_tready  <= 1'b0;
         stall_count <= stall_count - 1;
      end else if (hold_trigger) begin
         rsp_tready  <= 1'b0;
         stall_count <= HOLD_CYCLES;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // Compare every accepted digest word with the oldest queued one.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (digest_q.size() == 0) begin
            $error("unexpected digest word %h (index %0d)", rsp_tdata[31:0], rsp_tdata[34:32]);
            error_count++;
         end else begin
            want_word = digest_q.pop_front();
            if (rsp_tdata[31:0] !== want_word.word) begin
               $error("digest_word: expected %h, got %h", want_word.word, rsp_tdata[31:0]);
               error_count++;
            end
            if (rsp_tdata[34:32] !== want_word.index) begin
               $error("word_index: expected %0d, got %0d", want_word.index, rsp_tdata[34:32]);
               error_count++;
            end
            if (rsp_tlast !== want_word.last) begin
               $error("last_word: expected %0b, got %0b", want_word.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // Offer one word, with random idle cycles ahead of it, until accepted.
   task automatic send_word(input logic kind, input logic [7:0] data);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom_range(255));
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      hash_accepted_word(kind, data);
   endtask

   // A message of random bytes closed by a finish word.
   task automatic send_message(input int unsigned len);
      for (int i = 0; i < len; i++) begin
         send_word(KIND_APPEND, 8'($urandom_range(255)));
      end
      send_word(KIND_FINISH, 8'($urandom_range(255)));
   endtask

   // Stop offering and wait until every queued digest word has come out or the drain limit runs out.
   task automatic drain_digests();
      int unsigned n;
      n = 0;
      req_tvalid <= 1'b0;
      while (digest_q.size() != 0 && n < DRAIN_LIMIT) begin
         @(posedge clock);
         n++;
      end
   endtask

   task automatic test_empty_message();
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      send_word(KIND_FINISH, 8'h00);
      send_word(KIND_FINISH, 8'hFF);
      drain_digests();
   endtask

   // Known short messages and the byte extremes.
   task automatic test_short_messages();
      send_word(KIND_APPEND, 8'h61);
      send_word(KIND_APPEND, 8'h62);
      send_word(KIND_APPEND, 8'h63);
      send_word(KIND_FINISH, 8'h00);
      send_word(KIND_APPEND, 8'h00);
      send_word(KIND_FINISH, 8'hFF);
      send_word(KIND_APPEND, 8'hFF);
      send_word(KIND_FINISH, 8'h00);
      drain_digests();
   endtask

   // Padding that just fits, that spills into a second block, and a full block.
   task automatic test_block_boundaries();
      send_message(55);
      send_message(56);
      send_message(64);
      drain_digests();
   endtask

   // Random messages, mostly short, sometimes at a block boundary.
   task automatic send_random_messages(input int unsigned budget);
      int unsigned sent;
      int unsigned len;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(9) == 0) begin
            case ($urandom_range(3))
               0: len = 55;
               1: len = 56;
               2: len = 63;
               default: len = 64;
            endcase
         end else begin
            len = $urandom_range(20);
         end
         send_message(len);
         sent += len + 1;
      end
      drain_digests();
   endtask

   task automatic test_random_sender_idle();
      tx_idle_pct  = 80;
      rx_stall_pct = 0;
      send_random_messages(20);
   endtask

   task automatic test_random_receiver_stall();
      tx_idle_pct  = 0;
      rx_stall_pct = 80;
      send_random_messages(20);
   endtask

   task automatic test_random_both_idle();
      tx_idle_pct  = 8;
      rx_stall_pct = 8;
      send_random_messages(20);
   endtask

   // Hold the output off for a long stretch while messages keep coming.
   task automatic test_output_backpressure();
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      hold_trigger <= 1'b1;
      @(posedge clock);
      hold_trigger <= 1'b0;
      send_message(4);
      send_message(20);
      send_message(2);
      drain_digests();
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tuser  = KIND_APPEND;
      start_new_message();
      for (int i = 0; i < 64; i++) begin
         hash_block[i] = 8'h00;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_message();
      test_short_messages();
      test_block_boundaries();
      test_random_sender_idle();
      test_random_receiver_stall();
      test_random_both_idle();
      test_output_backpressure();

      // Any digest word still queued never arrived.
      if (digest_q.size() != 0) begin
         $error("%0d digest words never arrived", digest_q.size());
         error_count += digest_q.size();
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: filelist.f
design/sha1bsh_pkg.sv
design/sha1_byte_stream_hasher_unit.sv
tb/sha1_byte_stream_hasher_unit_test.sv
